// ===== rtl/ptw_pkg.sv =====
// Shared constants and index helper for the page-table walker.
package ptw_pkg;

    localparam int unsigned VaddrWidth = 48;
    localparam int unsigned DataWidth  = 64;
    localparam int unsigned IdxWidth   = 9;
    localparam int unsigned LevelWidth = 2;

    // Walk levels: the level of the table whose entry is being read.
    localparam logic [LevelWidth-1:0] LVL_PML4 = 2'd0;
    localparam logic [LevelWidth-1:0] LVL_PDPT = 2'd1;
    localparam logic [LevelWidth-1:0] LVL_PD   = 2'd2;
    localparam logic [LevelWidth-1:0] LVL_PT   = 2'd3;

    // Input opcodes.
    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_READ_RESP = 1'b1;

    // Result kinds.
    localparam logic KIND_MEM_READ = 1'b0;
    localparam logic KIND_DONE     = 1'b1;

    localparam int unsigned PresentBit = 0;
    localparam int unsigned LargeBit   = 7;

    // Nine-bit table index of a virtual address at a given walk level.
    function automatic logic [IdxWidth-1:0] level_index(
        input logic [VaddrWidth-1:0] va,
        input logic [LevelWidth-1:0] lvl
    );
        logic [IdxWidth-1:0] idx;
        case (lvl)
            LVL_PML4: idx = va[47:39];
            LVL_PDPT: idx = va[38:30];
            LVL_PD:   idx = va[29:21];
            LVL_PT:   idx = va[20:12];
            default:  idx = '0;
        endcase
        return idx;
    endfunction

endpackage

// ===== rtl/four_level_page_table_walker.sv =====
// Four-level 48-bit page-table walker, top level.
//
// Usage:
//   s_ channel carries one beat per request or memory response: s_op = 0 is a
//   translate request (s_virt_addr), s_op = 1 is a table entry returned by
//   memory (s_read_data). m_ channel returns results: m_kind = 0 asks memory
//   for the 8-byte entry at m_mem_addr, m_kind = 1 ends the walk with
//   m_phys_addr and m_fault. The caller answers each read request with one
//   response beat. A request seen during a walk and a response seen while
//   idle are consumed and produce nothing.
//   cfg_ channel writes root_table_base (low 12 bits ignored); write it only
//   while no walk is pending. cfg_ready is always high.
// Timing:
//   An accepted s_ beat has its result in the m_ output register next cycle.
//   One beat per cycle sustained while m_ready is high: the whole decision
//   is one level of index mux, mask and merge ahead of the output register.
// Reset (aresetn low, synchronous): walker idle, level 0, root base 0,
//   output register empty.
// Stall: while m_ready is low and a result is held, s_ready drops; nothing
//   is lost and the held result stays put.
module four_level_page_table_walker (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ptw_pkg::DataWidth-1:0]     cfg_wdata,
    // input beats
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic [ptw_pkg::VaddrWidth-1:0]    s_virt_addr,
    input  logic [ptw_pkg::DataWidth-1:0]     s_read_data,
    // result beats
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_kind,
    output logic [ptw_pkg::DataWidth-1:0]     m_mem_addr,
    output logic [ptw_pkg::DataWidth-1:0]     m_phys_addr,
    output logic                              m_fault
);

    // walk state
    logic [ptw_pkg::DataWidth-1:0]  root_base_reg;
    logic                           busy_reg, busy_next;
    logic [ptw_pkg::LevelWidth-1:0] level_reg, level_next;
    logic [ptw_pkg::VaddrWidth-1:0] vaddr_reg, vaddr_next;

    // output register
    logic                           out_valid_reg, out_valid_next;
    logic                           kind_reg, kind_next;
    logic [ptw_pkg::DataWidth-1:0]  mem_addr_reg, mem_addr_next;
    logic [ptw_pkg::DataWidth-1:0]  phys_addr_reg, phys_addr_next;
    logic                           fault_reg, fault_next;

    logic                           in_fire;
    logic                           emit;
    logic [ptw_pkg::DataWidth-1:0]  entry;
    logic [ptw_pkg::LevelWidth-1:0] next_level;

    assign cfg_ready = 1'b1;
    // Output slot frees when empty or being drained this cycle.
    assign s_ready   = !out_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;
    assign entry     = s_read_data;
    assign next_level = level_reg + 2'd1;

    always_comb begin
        busy_next      = busy_reg;
        level_next     = level_reg;
        vaddr_next     = vaddr_reg;
        emit           = 1'b0;
        kind_next      = ptw_pkg::KIND_MEM_READ;
        mem_addr_next  = '0;
        phys_addr_next = '0;
        fault_next     = 1'b0;

        if (in_fire) begin
            if (s_op == ptw_pkg::OP_TRANSLATE) begin
                if (!busy_reg) begin
                    // start walk: read top-level entry
                    busy_next     = 1'b1;
                    level_next    = ptw_pkg::LVL_PML4;
                    vaddr_next    = s_virt_addr;
                    emit          = 1'b1;
                    mem_addr_next = {root_base_reg[63:12],
                                     ptw_pkg::level_index(s_virt_addr, ptw_pkg::LVL_PML4),
                                     3'b000};
                end
            end else if (busy_reg) begin
                emit = 1'b1;
                if (!entry[ptw_pkg::PresentBit]) begin
                    busy_next  = 1'b0;
                    kind_next  = ptw_pkg::KIND_DONE;
                    fault_next = 1'b1;
                end else if (level_reg == ptw_pkg::LVL_PD && entry[ptw_pkg::LargeBit]) begin
                    // 2 MiB page
                    busy_next      = 1'b0;
                    kind_next      = ptw_pkg::KIND_DONE;
                    phys_addr_next = {entry[63:21], vaddr_reg[20:0]};
                end else if (level_reg == ptw_pkg::LVL_PT) begin
                    // 4 KiB page
                    busy_next      = 1'b0;
                    kind_next      = ptw_pkg::KIND_DONE;
                    phys_addr_next = {entry[63:12], vaddr_reg[11:0]};
                end else begin
                    level_next    = next_level;
                    mem_addr_next = {entry[63:12],
                                     ptw_pkg::level_index(vaddr_reg, next_level),
                                     3'b000};
                end
            end
        end

        if (in_fire) begin
            out_valid_next = emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_base_reg <= '0;
            busy_reg      <= 1'b0;
            level_reg     <= ptw_pkg::LVL_PML4;
            vaddr_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                root_base_reg <= cfg_wdata;
            end
            busy_reg      <= busy_next;
            level_reg     <= level_next;
            vaddr_reg     <= vaddr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (in_fire && emit) begin
            kind_reg      <= kind_next;
            mem_addr_reg  <= mem_addr_next;
            phys_addr_reg <= phys_addr_next;
            fault_reg     <= fault_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_kind      = kind_reg;
    assign m_mem_addr  = mem_addr_reg;
    assign m_phys_addr = phys_addr_reg;
    assign m_fault     = fault_reg;

    // A translate request taken while idle starts a walk.
    a_start_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_op == ptw_pkg::OP_TRANSLATE && !busy_reg) |=> busy_reg)
        else $error("walk did not start");

    // Every response taken during a walk yields a result beat.
    a_resp_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_op == ptw_pkg::OP_READ_RESP && busy_reg) |=> m_valid)
        else $error("response lost");

    // A fault is a finished walk with a zero address.
    a_fault_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_fault) |-> (m_kind == ptw_pkg::KIND_DONE && m_phys_addr == '0))
        else $error("malformed fault beat");

    // Read requests are 8-byte aligned and carry no translation.
    a_read_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == ptw_pkg::KIND_MEM_READ) |->
            (m_mem_addr[2:0] == 3'b000 && m_phys_addr == '0 && !m_fault))
        else $error("malformed read beat");

endmodule
